// ===== rtl/adjacency_matrix_edge_store_top_macros.svh =====
// assertion helpers for the edge store top
`ifndef ADJACENCY_MATRIX_EDGE_STORE_TOP_MACROS_SVH
`define ADJACENCY_MATRIX_EDGE_STORE_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define AMES_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define AMES_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/ames_pkg.sv =====
package ames_pkg;

   localparam int AMES_MAX_VERTICES = 16;
   localparam int AMES_WEIGHT_BITS  = 16;

   localparam int VCOUNT_BITS  = 5;
   localparam int VALUE_BITS   = 16;
   localparam int EDGE_BITS    = 9;
   localparam int MAX_LISTED   = 16;
   localparam int LISTED_BITS  = $clog2(MAX_LISTED + 1);

   localparam logic [VCOUNT_BITS-1:0] VCOUNT_RESET = VCOUNT_BITS'(16);

   typedef enum logic [1:0] {
      OP_INSERT    = 2'd0,
      OP_REMOVE    = 2'd1,
      OP_FIND      = 2'd2,
      OP_NEIGHBORS = 2'd3
   } op_type;

   localparam logic [1:0] KIND_ACK   = 2'd0;
   localparam logic [1:0] KIND_FOUND = 2'd1;
   localparam logic [1:0] KIND_COUNT = 2'd2;
   localparam logic [1:0] KIND_INDEX = 2'd3;

   localparam logic [1:0] STAT_DONE     = 2'd0;
   localparam logic [1:0] STAT_RANGE    = 2'd1;
   localparam logic [1:0] STAT_NO_MATCH = 2'd2;
   localparam logic [1:0] STAT_ZERO_WT  = 2'd3;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_COUNT,
      ST_LIST
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
   } ames_scan_ctrl_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] count;
      logic [VALUE_BITS-1:0] index;
      logic                  empty;
      logic                  last_hit;
   } ames_scan_stat_type;

endpackage

// ===== rtl/ames_row_ram.sv =====
module ames_row_ram import ames_pkg::*; #(
   parameter int DEPTH = AMES_MAX_VERTICES,
   parameter int WIDTH = AMES_MAX_VERTICES * AMES_WEIGHT_BITS
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/ames_nbr_scan.sv =====
module ames_nbr_scan import ames_pkg::*; #(
   parameter int MAX_VERTICES = AMES_MAX_VERTICES,
   parameter int WEIGHT_BITS  = AMES_WEIGHT_BITS,
   localparam int LIMIT_BITS  = ($clog2(MAX_VERTICES + 1) > VCOUNT_BITS) ?
                                $clog2(MAX_VERTICES + 1) : VCOUNT_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ames_scan_ctrl_type                  ctrl,
   input  logic [MAX_VERTICES*WEIGHT_BITS-1:0] row_data,
   input  logic [LIMIT_BITS-1:0]               limit,
   output ames_scan_stat_type                  stat
);

   logic [MAX_VERTICES-1:0] mask_ff, mask_in;
   logic [MAX_VERTICES-1:0] row_mask;
   logic [MAX_VERTICES-1:0] rest_mask;
   logic [LISTED_BITS-1:0]  listed_ff, listed_in;
   logic [VALUE_BITS-1:0]   pop;
   logic [VALUE_BITS-1:0]   low_idx;

   // nonzero entries in the columns that are in use
   always_comb begin
      for (int c = 0; c < MAX_VERTICES; c++) begin
         row_mask[c] = (row_data[c*WEIGHT_BITS +: WEIGHT_BITS] != '0) &&
                       (LIMIT_BITS'(c) < limit);
      end
   end

   always_comb begin
      pop     = '0;
      low_idx = '0;
      for (int c = 0; c < MAX_VERTICES; c++) begin
         pop = pop + VALUE_BITS'(mask_ff[c]);
      end
      for (int c = MAX_VERTICES - 1; c >= 0; c--) begin
         if (mask_ff[c]) begin
            low_idx = VALUE_BITS'(c);
         end
      end
   end

   assign rest_mask = mask_ff & (mask_ff - MAX_VERTICES'(1));

   always_comb begin
      mask_in   = mask_ff;
      listed_in = listed_ff;
      priority if (ctrl.load) begin
         mask_in   = row_mask;
         listed_in = '0;
      end else if (ctrl.step) begin
         mask_in   = rest_mask;
         listed_in = listed_ff + LISTED_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff   <= '0;
         listed_ff <= '0;
      end else begin
         mask_ff   <= mask_in;
         listed_ff <= listed_in;
      end
   end

   assign stat.count    = pop;
   assign stat.index    = low_idx;
   assign stat.empty    = (mask_ff == '0);
   assign stat.last_hit = (rest_mask == '0) ||
                          (listed_ff == LISTED_BITS'(MAX_LISTED - 1));

endmodule

// ===== rtl/adjacency_matrix_edge_store_top.sv =====
// weighted adjacency matrix edge store. a square matrix of signed edge
// weights sits in a row-wide synchronous ram, one row per source vertex,
// zero meaning no edge, with a running count of nonzero entries beside it.
// a command word is taken when start is high and busy is low; the block then
// holds busy until its work is done. results come out on rsp_* for exactly
// one cycle each, marked by rsp_strobe, and cannot be stalled: the receiver
// must take every word the cycle it appears. the row is read at the edge
// that takes the command. insert, remove and find keep busy through the
// lookup state alone (modify and write back) and give one word the cycle
// after it; no new command is taken until busy drops. a neighbor listing
// keeps busy through the lookup state, the count state for the count word,
// then the list state for the index words, at most 16, one index word per
// cycle, lowest first, last flagged. the busy time is set by the single row
// read per command and by handing out one neighbor index per cycle. after
// reset a clearing pass zeroes the ram one row per cycle with busy high;
// csr writes of vertex_count are taken at any time but should only be made
// while idle.
`include "adjacency_matrix_edge_store_top_macros.svh"

module adjacency_matrix_edge_store_top import ames_pkg::*; #(
   parameter int MAX_VERTICES = AMES_MAX_VERTICES,
   parameter int WEIGHT_BITS  = AMES_WEIGHT_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   // command side
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_operation,
   input  logic [3:0]                    req_from_vertex,
   input  logic [3:0]                    req_to_vertex,
   input  logic signed [VALUE_BITS-1:0]  req_weight,
   // result side
   output logic                          rsp_strobe,
   output logic [1:0]                    rsp_result_kind,
   output logic signed [VALUE_BITS-1:0]  rsp_value,
   output logic [1:0]                    rsp_status,
   output logic [EDGE_BITS-1:0]          rsp_edge_count,
   output logic                          rsp_last,
   // configuration
   input  logic                          csr_write_enable,
   input  logic [VCOUNT_BITS-1:0]        csr_write_data
);

   localparam int ADDR_BITS  = $clog2(MAX_VERTICES);
   localparam int ROW_BITS   = MAX_VERTICES * WEIGHT_BITS;
   localparam int LIMIT_BITS = ($clog2(MAX_VERTICES + 1) > VCOUNT_BITS) ?
                               $clog2(MAX_VERTICES + 1) : VCOUNT_BITS;

   state_type               state_ff, state_in;
   logic [ADDR_BITS-1:0]    clear_row_ff, clear_row_in;
   logic [VCOUNT_BITS-1:0]  vertex_count_ff;
   logic [EDGE_BITS-1:0]    edges_ff, edges_in;

   // captured command word
   op_type                  op_ff;
   logic [3:0]              from_ff;
   logic [3:0]              to_ff;
   logic [WEIGHT_BITS-1:0]  weight_ff;
   logic                    range_err_ff;

   // output register
   logic                    rsp_strobe_ff, rsp_strobe_in;
   logic [1:0]              rsp_kind_ff, rsp_kind_in;
   logic [VALUE_BITS-1:0]   rsp_value_ff, rsp_value_in;
   logic [1:0]              rsp_status_ff, rsp_status_in;
   logic [EDGE_BITS-1:0]    rsp_edges_ff;
   logic                    rsp_last_ff, rsp_last_in;

   // ram port signals
   logic                    mem_wr_en;
   logic [ADDR_BITS-1:0]    mem_wr_addr;
   logic [ROW_BITS-1:0]     mem_wr_data;
   logic                    mem_rd_en;
   logic [ROW_BITS-1:0]     mem_rd_data;

   logic                    accept;
   op_type                  req_op;
   logic [LIMIT_BITS-1:0]   limit;
   logic                    from_bad, to_bad;
   logic signed [31:0]      req_w_ext;
   logic [ADDR_BITS-1:0]    col;
   logic signed [WEIGHT_BITS-1:0] cur_w;
   logic signed [31:0]      cur_w_ext;
   logic [WEIGHT_BITS-1:0]  new_w;
   logic [ROW_BITS-1:0]     new_row;

   ames_scan_ctrl_type      scan_ctrl;
   ames_scan_stat_type      scan_stat;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign req_op = op_type'(req_operation);

   // vertices in use, saturated at the built size
   assign limit = (LIMIT_BITS'(vertex_count_ff) < LIMIT_BITS'(MAX_VERTICES)) ?
                  LIMIT_BITS'(vertex_count_ff) : LIMIT_BITS'(MAX_VERTICES);
   assign from_bad = (LIMIT_BITS'(req_from_vertex) >= limit);
   assign to_bad   = (LIMIT_BITS'(req_to_vertex) >= limit);

   // weight sign-extended to 32 bits; the capture keeps the stored width
   assign req_w_ext = 32'(req_weight);

   // entry under edit, read back out of the row
   assign col       = ADDR_BITS'(to_ff);
   assign cur_w     = mem_rd_data[col*WEIGHT_BITS +: WEIGHT_BITS];
   assign cur_w_ext = 32'(cur_w);
   assign new_w     = (op_ff == OP_REMOVE) ? '0 : weight_ff;

   always_comb begin
      for (int c = 0; c < MAX_VERTICES; c++) begin
         new_row[c*WEIGHT_BITS +: WEIGHT_BITS] =
            (ADDR_BITS'(c) == col) ? new_w : mem_rd_data[c*WEIGHT_BITS +: WEIGHT_BITS];
      end
   end

   // the row is read as the word is taken; busy keeps the next read
   // behind this one's write back
   assign mem_rd_en = accept;

   ames_row_ram #(
      .DEPTH (MAX_VERTICES),
      .WIDTH (ROW_BITS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (ADDR_BITS'(req_from_vertex)),
      .rd_data (mem_rd_data)
   );

   ames_nbr_scan #(
      .MAX_VERTICES (MAX_VERTICES),
      .WEIGHT_BITS  (WEIGHT_BITS)
   ) u_nbr_scan (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (scan_ctrl),
      .row_data (mem_rd_data),
      .limit    (limit),
      .stat     (scan_stat)
   );

   // sequencer: next state, ram write, result word
   always_comb begin
      state_in      = state_ff;
      clear_row_in  = clear_row_ff;
      edges_in      = edges_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = ADDR_BITS'(from_ff);
      mem_wr_data   = new_row;
      scan_ctrl     = '0;
      rsp_strobe_in = 1'b0;
      rsp_kind_in   = KIND_ACK;
      rsp_value_in  = '0;
      rsp_status_in = STAT_DONE;
      rsp_last_in   = 1'b1;

      unique case (state_ff)
         ST_CLEAR: begin
            // zero one row per cycle after reset
            mem_wr_en    = 1'b1;
            mem_wr_addr  = clear_row_ff;
            mem_wr_data  = '0;
            clear_row_in = clear_row_ff + ADDR_BITS'(1);
            if (clear_row_ff == ADDR_BITS'(MAX_VERTICES - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOOKUP;
            end
         end

         ST_LOOKUP: begin
            state_in = ST_IDLE;
            if (range_err_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = STAT_RANGE;
               rsp_kind_in   = (op_ff == OP_FIND) ? KIND_FOUND :
                               (op_ff == OP_NEIGHBORS) ? KIND_COUNT : KIND_ACK;
            end else begin
               unique case (op_ff)
                  OP_INSERT: begin
                     rsp_strobe_in = 1'b1;
                     if (weight_ff == '0) begin
                        rsp_status_in = STAT_ZERO_WT;
                     end else begin
                        mem_wr_en = 1'b1;
                        if (cur_w == '0) begin
                           edges_in = edges_ff + EDGE_BITS'(1);
                        end
                     end
                  end
                  OP_REMOVE: begin
                     rsp_strobe_in = 1'b1;
                     if ((cur_w != '0) && (cur_w == weight_ff)) begin
                        mem_wr_en = 1'b1;
                        edges_in  = edges_ff - EDGE_BITS'(1);
                     end else begin
                        rsp_status_in = STAT_NO_MATCH;
                     end
                  end
                  OP_FIND: begin
                     rsp_strobe_in = 1'b1;
                     rsp_kind_in   = KIND_FOUND;
                     rsp_value_in  = cur_w_ext[VALUE_BITS-1:0];
                  end
                  OP_NEIGHBORS: begin
                     // hand the row to the scanner, count word next
                     scan_ctrl.load = 1'b1;
                     state_in       = ST_COUNT;
                  end
               endcase
            end
         end

         ST_COUNT: begin
            rsp_strobe_in = 1'b1;
            rsp_kind_in   = KIND_COUNT;
            rsp_value_in  = scan_stat.count;
            rsp_last_in   = scan_stat.empty;
            state_in      = scan_stat.empty ? ST_IDLE : ST_LIST;
         end

         ST_LIST: begin
            rsp_strobe_in  = 1'b1;
            rsp_kind_in    = KIND_INDEX;
            rsp_value_in   = scan_stat.index;
            rsp_last_in    = scan_stat.last_hit;
            scan_ctrl.step = 1'b1;
            if (scan_stat.last_hit) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clear_row_ff    <= '0;
         vertex_count_ff <= VCOUNT_RESET;
         edges_ff        <= '0;
         rsp_strobe_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_row_ff  <= clear_row_in;
         edges_ff      <= edges_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_write_enable) begin
            vertex_count_ff <= csr_write_data;
         end
      end
   end

   // command capture
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff        <= req_op;
         from_ff      <= req_from_vertex;
         to_ff        <= req_to_vertex;
         weight_ff    <= req_w_ext[WEIGHT_BITS-1:0];
         range_err_ff <= (req_op == OP_NEIGHBORS) ? from_bad : (from_bad || to_bad);
      end
   end

   // result payload, count is the one after the command
   always_ff @(posedge clock) begin
      rsp_kind_ff   <= rsp_kind_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_edges_ff  <= edges_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_value       = rsp_value_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_edge_count  = rsp_edges_ff;
   assign rsp_last        = rsp_last_ff;

   // a result word only follows a cycle of real work
   `AMES_ASSERT_IMPLY(a_rsp_after_work, clock, reset, rsp_strobe_ff, $past(state_ff == ST_LOOKUP || state_ff == ST_COUNT || state_ff == ST_LIST), "result word without work")
   // entries are reachable only through 4-bit vertices
   `AMES_ASSERT_IMPLY(a_edges_bound, clock, reset, 1'b1, edges_ff <= EDGE_BITS'(256), "edge count out of bounds")
   // no ram write while a new row read is issued
   `AMES_ASSERT_IMPLY(a_no_wr_on_read, clock, reset, mem_rd_en, !mem_wr_en, "ram write during row read")
   // listing only while neighbors remain
   `AMES_ASSERT_IMPLY(a_list_nonempty, clock, reset, state_ff == ST_LIST, !scan_stat.empty, "listing with empty mask")
   // a valid neighbor command always goes on to the count word
   `AMES_ASSERT_NEXT(a_nbr_to_count, clock, reset, state_ff == ST_LOOKUP && !range_err_ff && op_ff == OP_NEIGHBORS, state_ff == ST_COUNT, "neighbor listing lost")

endmodule

// ===== tb/sv/adjacency_matrix_edge_store_top_tb.sv =====
module adjacency_matrix_edge_store_top_tb;
   import ames_pkg::*;

   // run ends here even if the block hangs
   localparam int CYCLE_LIMIT = 300000;

   // one result word as the block should produce it
   typedef struct {
      logic [1:0]                   kind;
      logic signed [VALUE_BITS-1:0] value;
      logic [1:0]                   status;
      logic [EDGE_BITS-1:0]         edge_count;
      logic                         last;
   } rsp_word_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic [1:0]                   req_operation = OP_INSERT;
   logic [3:0]                   req_from_vertex = '0;
   logic [3:0]                   req_to_vertex = '0;
   logic signed [VALUE_BITS-1:0] req_weight = '0;
   logic                         rsp_strobe;
   logic [1:0]                   rsp_result_kind;
   logic signed [VALUE_BITS-1:0] rsp_value;
   logic [1:0]                   rsp_status;
   logic [EDGE_BITS-1:0]         rsp_edge_count;
   logic                         rsp_last;
   logic                         csr_write_enable = 1'b0;
   logic [VCOUNT_BITS-1:0]       csr_write_data = '0;

   // shadow of the matrix, the edge count and the vertex count register
   logic signed [VALUE_BITS-1:0] weight_table [AMES_MAX_VERTICES][AMES_MAX_VERTICES];
   int                           edge_total;
   logic [VCOUNT_BITS-1:0]       vertex_count_cfg;

   // result words still owed by the block, oldest first
   rsp_word_type                 expected_words [$];
   int                           mismatch_count = 0;
   int                           cycle_count = 0;
   // when set the sender never pauses between words
   bit                           steady_run = 1'b0;

   adjacency_matrix_edge_store_top uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_from_vertex  (req_from_vertex),
      .req_to_vertex    (req_to_vertex),
      .req_weight       (req_weight),
      .rsp_strobe       (rsp_strobe),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_value        (rsp_value),
      .rsp_status       (rsp_status),
      .rsp_edge_count   (rsp_edge_count),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // vertices in use, saturated at the built matrix size
   function automatic int vertex_limit();
      return (vertex_count_cfg < AMES_MAX_VERTICES) ? int'(vertex_count_cfg)
                                                    : AMES_MAX_VERTICES;
   endfunction

   // queue one owed word, tagged with the edge count as it stands now
   function automatic void owe_word(logic [1:0] kind, int value, logic [1:0] status,
                                    bit last);
      rsp_word_type w;
      w.kind       = kind;
      w.value      = VALUE_BITS'(value);
      w.status     = status;
      w.edge_count = EDGE_BITS'(edge_total);
      w.last       = last;
      expected_words.push_back(w);
   endfunction

   // apply one accepted command to the shadow matrix and owe its words
   function automatic void predict_edge_op(op_type op, logic [3:0] src, logic [3:0] dst,
                                           logic signed [VALUE_BITS-1:0] wt);
      int lim;
      int n;
      int listed;
      lim = vertex_limit();
      if (op == OP_NEIGHBORS) begin
         if (src >= lim) begin
            owe_word(KIND_COUNT, 0, STAT_RANGE, 1'b1);
            return;
         end
         n = 0;
         for (int i = 0; i < lim; i++)
            if (weight_table[src][i] != 0) n++;
         owe_word(KIND_COUNT, n, STAT_DONE, n == 0);
         // count word first, then the lowest indexes, last one flagged
         listed = 0;
         for (int i = 0; i < lim && listed < MAX_LISTED; i++) begin
            if (weight_table[src][i] != 0) begin
               listed++;
               owe_word(KIND_INDEX, i, STAT_DONE, listed == n || listed == MAX_LISTED);
            end
         end
         return;
      end
      if (src >= lim || dst >= lim) begin
         owe_word((op == OP_FIND) ? KIND_FOUND : KIND_ACK, 0, STAT_RANGE, 1'b1);
         return;
      end
      case (op)
         OP_INSERT: begin
            if (wt == 0) begin
               owe_word(KIND_ACK, 0, STAT_ZERO_WT, 1'b1);
            end else begin
               if (weight_table[src][dst] == 0) edge_total++;
               weight_table[src][dst] = wt;
               owe_word(KIND_ACK, 0, STAT_DONE, 1'b1);
            end
         end
         OP_REMOVE: begin
            if (weight_table[src][dst] != 0 && weight_table[src][dst] == wt) begin
               weight_table[src][dst] = '0;
               edge_total--;
               owe_word(KIND_ACK, 0, STAT_DONE, 1'b1);
            end else begin
               owe_word(KIND_ACK, 0, STAT_NO_MATCH, 1'b1);
            end
         end
         default: begin
            owe_word(KIND_FOUND, int'(weight_table[src][dst]), STAT_DONE, 1'b1);
         end
      endcase
   endfunction

   // every strobed word is checked against the oldest owed word
   always @(posedge clock) begin : check_words
      rsp_word_type w;
      if (!reset && rsp_strobe === 1'b1) begin
         if (expected_words.size() == 0) begin
            $error("unexpected result word: kind %0d value %0d status %0d",
                   rsp_result_kind, rsp_value, rsp_status);
            mismatch_count++;
         end else begin
            w = expected_words.pop_front();
            if (rsp_result_kind !== w.kind) begin
               $error("result_kind: expected %0d, got %0d", w.kind, rsp_result_kind);
               mismatch_count++;
            end
            if (rsp_value !== w.value) begin
               $error("value: expected %0d, got %0d", w.value, rsp_value);
               mismatch_count++;
            end
            if (rsp_status !== w.status) begin
               $error("status: expected %0d, got %0d", w.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_edge_count !== w.edge_count) begin
               $error("edge_count: expected %0d, got %0d", w.edge_count, rsp_edge_count);
               mismatch_count++;
            end
            if (rsp_last !== w.last) begin
               $error("last: expected %0d, got %0d", w.last, rsp_last);
               mismatch_count++;
            end
         end
      end
   end

   // present one command word and hold it until the block takes it;
   // start is left high so a following word goes out back to back
   task automatic send_word(op_type op, logic [3:0] src, logic [3:0] dst,
                            logic signed [VALUE_BITS-1:0] wt);
      if (!steady_run && $urandom_range(99) < 18) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      start           <= 1'b1;
      req_operation   <= op;
      req_from_vertex <= src;
      req_to_vertex   <= dst;
      req_weight      <= wt;
      // busy read here is the value the block saw at this edge
      do @(posedge clock); while (busy !== 1'b0);
      predict_edge_op(op, src, dst, wt);
   endtask

   // drop start and wait for every owed word plus a short settle
   task automatic wait_idle();
      start <= 1'b0;
      while (expected_words.size() != 0 || busy !== 1'b0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // register write, only once the block is quiet
   task automatic set_vertex_count(logic [VCOUNT_BITS-1:0] v);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      vertex_count_cfg = v;
   endtask

   // mostly in range vertices, sometimes anything the field can hold
   function automatic logic [3:0] pick_vertex(int lim);
      if (lim > 0 && $urandom_range(99) < 88) return 4'($urandom_range(lim - 1));
      return 4'($urandom_range(15));
   endfunction

   // zero, small, extreme and fully random weights
   function automatic logic signed [VALUE_BITS-1:0] pick_weight();
      int r;
      r = $urandom_range(99);
      if (r < 8) return '0;
      if (r < 40) return VALUE_BITS'($urandom_range(1, 9));
      if (r < 45) return 16'sh8000;
      if (r < 50) return 16'sh7fff;
      if (r < 55) return -16'sd1;
      return VALUE_BITS'($urandom());
   endfunction

   // one random command; rows are kept dense and removes mostly match
   task automatic random_item();
      int lim;
      int r;
      op_type op;
      logic [3:0] src;
      logic [3:0] dst;
      logic signed [VALUE_BITS-1:0] wt;
      lim = vertex_limit();
      r = $urandom_range(99);
      if (r < 40) op = OP_INSERT;
      else if (r < 65) op = OP_REMOVE;
      else if (r < 80) op = OP_FIND;
      else op = OP_NEIGHBORS;
      src = pick_vertex(lim);
      if (lim > 0 && $urandom_range(1)) src = 4'($urandom_range(((lim < 3) ? lim : 3) - 1));
      dst = pick_vertex(lim);
      wt = pick_weight();
      if (op == OP_REMOVE && $urandom_range(99) < 65) wt = weight_table[src][dst];
      send_word(op, src, dst, wt);
   endtask

   task automatic random_run(int count);
      repeat (count) random_item();
   endtask

   // extremes of weight and vertex fields, plus plain lookups
   task automatic test_insert_find_extremes();
      send_word(OP_INSERT, 4'd0, 4'd0, 16'sh7fff);
      send_word(OP_INSERT, 4'd15, 4'd15, 16'sh8000);
      send_word(OP_INSERT, 4'd0, 4'd15, 16'sd1);
      send_word(OP_INSERT, 4'd0, 4'd7, -16'sd1);
      send_word(OP_FIND, 4'd0, 4'd0, 16'sh5555);
      send_word(OP_FIND, 4'd15, 4'd15, 16'shaaaa);
      send_word(OP_FIND, 4'd3, 4'd4, 16'sd0);
   endtask

   // listing of several neighbors, empty row, single neighbor
   task automatic test_neighbor_listing();
      send_word(OP_NEIGHBORS, 4'd0, 4'd9, 16'sd3);
      send_word(OP_NEIGHBORS, 4'd9, 4'd0, 16'sd0);
      send_word(OP_NEIGHBORS, 4'd15, 4'd15, 16'sd0);
   endtask

   // zero weight is refused, an insert on an edge replaces it
   task automatic test_zero_and_overwrite();
      send_word(OP_INSERT, 4'd2, 4'd3, 16'sd0);
      send_word(OP_INSERT, 4'd0, 4'd0, -16'sd2);
      send_word(OP_FIND, 4'd0, 4'd0, 16'sd0);
   endtask

   // wrong weight, absent edge, match, then the same remove again
   task automatic test_remove_cases();
      send_word(OP_REMOVE, 4'd0, 4'd0, 16'sd5);
      send_word(OP_REMOVE, 4'd4, 4'd4, 16'sd0);
      send_word(OP_REMOVE, 4'd0, 4'd0, -16'sd2);
      send_word(OP_REMOVE, 4'd0, 4'd0, -16'sd2);
   endtask

   // out of range vertices on each operation, shrunk row scan, no vertices at all
   task automatic test_out_of_range();
      set_vertex_count(5'd8);
      send_word(OP_INSERT, 4'd8, 4'd0, 16'sd3);
      send_word(OP_REMOVE, 4'd1, 4'd9, 16'sd1);
      send_word(OP_FIND, 4'd0, 4'd12, 16'sd0);
      send_word(OP_NEIGHBORS, 4'd8, 4'd0, 16'sd0);
      // entry at column 15 stays in the edge count but is not counted or listed
      send_word(OP_NEIGHBORS, 4'd0, 4'd0, 16'sd0);
      set_vertex_count(5'd0);
      send_word(OP_FIND, 4'd0, 4'd0, 16'sd0);
      send_word(OP_NEIGHBORS, 4'd0, 4'd0, 16'sd0);
   endtask

   // random traffic with the full matrix in use
   task automatic test_random_full_size();
      set_vertex_count(5'd16);
      random_run(40);
   endtask

   // saturated register: fill one row completely, list it, then a long
   // stretch with no pauses on the command side
   task automatic test_saturated_count();
      set_vertex_count(5'd31);
      for (int i = 0; i < AMES_MAX_VERTICES; i++)
         send_word(OP_INSERT, 4'd5, 4'(i), VALUE_BITS'($urandom_range(1, 65535)));
      send_word(OP_NEIGHBORS, 4'd5, 4'd0, 16'sd0);
      steady_run = 1'b1;
      random_run(40);
      steady_run = 1'b0;
   endtask

   // single vertex, a random middle size, no vertices, then back to full
   task automatic test_other_sizes();
      set_vertex_count(5'd1);
      random_run(25);
      set_vertex_count(VCOUNT_BITS'($urandom_range(2, 15)));
      random_run(50);
      set_vertex_count(5'd0);
      random_run(10);
      set_vertex_count(VCOUNT_BITS'(16));
      random_run(20);
   endtask

   initial begin
      for (int r = 0; r < AMES_MAX_VERTICES; r++)
         for (int c = 0; c < AMES_MAX_VERTICES; c++)
            weight_table[r][c] = '0;
      edge_total = 0;
      vertex_count_cfg = VCOUNT_RESET;

      // reset is held, then released, and the block runs its clearing pass
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_insert_find_extremes();
      test_neighbor_listing();
      test_zero_and_overwrite();
      test_remove_cases();
      test_out_of_range();
      test_random_full_size();
      test_saturated_count();
      test_other_sizes();

      // let any stray word show up before the verdict
      wait_idle();
      repeat (24) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
